// ===== hdl/psc_pkg.sv =====
`default_nettype none
package psc_pkg;

  localparam int ANGLE_FRAC_BITS  = 16;
  localparam int RESULT_FRAC_BITS = 16;
  localparam int WORK_BITS        = 28;

  localparam int ANGLE_W = 32;
  localparam int VALUE_W = 18;
  localparam int X_W     = 19;

  // pipeline layout: reduction stages first, then the polynomial stages
  localparam int STAGES     = 12;
  localparam int RED_STAGES = 5;

  localparam logic CMD_SINE   = 1'b0;
  localparam logic CMD_COSINE = 1'b1;

  // angle constants at ANGLE_FRAC_BITS fraction bits, rounded to nearest
  localparam logic [18:0] PI_A      = 19'd205887;
  localparam logic [18:0] TWO_PI_A  = 19'd411775;
  localparam logic [18:0] HALF_PI_A = 19'd102944;
  localparam logic [19:0] FOUR_PI_A = 20'd823550;

  // bias that makes angle + pi non-negative, a whole number of turns plus pi
  localparam logic [32:0] RED_OFFSET = 33'd2148024287;
  // floor(2^33 / two_pi), applied to the angle with its low 8 bits dropped
  localparam logic [14:0] RECIP_M = 15'd20860;

  // polynomial constants with 32 fraction bits
  localparam logic [32:0] K_FOUR_OVER_PI    = 33'd5468522184;
  localparam logic [30:0] K_FOUR_OVER_PI_SQ = 31'd1740684682;
  localparam logic [29:0] K_REFINE          = 30'd966367642;

  localparam logic signed [21:0] VALUE_MAX = 22'sd131071;
  localparam logic signed [21:0] VALUE_MIN = -22'sd131072;

  typedef struct packed {
    logic [STAGES-1:0] en;
  } psc_ctrl_t;

endpackage
`default_nettype wire

// ===== hdl/psc_in_if.sv =====
`default_nettype none
interface psc_in_if import psc_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic signed [ANGLE_W-1:0] angle;

  modport source (output valid, output cmd, output angle, input ready);
  modport sink (input valid, input cmd, input angle, output ready);
endinterface
`default_nettype wire

// ===== hdl/psc_out_if.sv =====
`default_nettype none
interface psc_out_if import psc_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface
`default_nettype wire

// ===== hdl/psc_ctrl.sv =====
`default_nettype none
module psc_ctrl import psc_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      out_ready,
  output psc_ctrl_t      ctrl,
  output logic           out_valid
);

  logic [STAGES-1:0] v_r;
  logic [STAGES-1:0] v_nxt;
  logic [STAGES-1:0] en;

  // a stage loads when it is empty or its contents move on
  always_comb begin
    en[STAGES-1] = !v_r[STAGES-1] || out_ready;
    for (int i = STAGES - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  always_comb begin
    v_nxt[0] = en[0] ? in_valid : v_r[0];
    for (int i = 1; i < STAGES; i++) begin
      v_nxt[i] = en[i] ? v_r[i-1] : v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign ctrl.en   = en;
  assign out_valid = v_r[STAGES-1];

endmodule
`default_nettype wire

// ===== hdl/psc_reduce.sv =====
`default_nettype none
module psc_reduce import psc_pkg::*; (
  input  wire logic                      clk,
  input  wire psc_ctrl_t                 ctrl,
  input  wire logic                      in_cmd,
  input  wire logic signed [ANGLE_W-1:0] in_angle,
  output logic signed [X_W-1:0]          x_out
);

  // stage 1: biased angle
  logic [33:0] u_sum;
  logic [32:0] u1_r;
  logic        cmd1_r;
  // stage 2: turn count estimate
  logic [39:0] q_prod;
  logic [13:0] q_r;
  logic [32:0] u2_r;
  logic        cmd2_r;
  // stage 3: estimate times two pi
  logic [32:0] qt_prod;
  logic [32:0] qt_r;
  logic [32:0] u3_r;
  logic        cmd3_r;
  // stage 4: remainder, corrected into one turn
  logic [32:0] diff;
  logic [20:0] rem0;
  logic [20:0] rem;
  logic signed [19:0] a_w;
  logic signed [X_W-1:0] a_r;
  logic        cmd4_r;
  // stage 5: cosine shift
  logic signed [19:0] b_w;
  logic signed [19:0] x_w;
  logic signed [X_W-1:0] x_r;

  assign u_sum   = {{2{in_angle[ANGLE_W-1]}}, in_angle} + {1'b0, RED_OFFSET};
  assign q_prod  = {15'd0, u1_r[32:8]} * {25'd0, RECIP_M};
  assign qt_prod = {19'd0, q_r} * {14'd0, TWO_PI_A};
  assign diff    = u3_r - qt_r;
  assign rem0    = diff[20:0];

  // the estimate is low by at most two turns
  always_comb begin
    if (rem0 >= {1'b0, FOUR_PI_A}) begin
      rem = rem0 - {1'b0, FOUR_PI_A};
    end else if (rem0 >= {2'b0, TWO_PI_A}) begin
      rem = rem0 - {2'b0, TWO_PI_A};
    end else begin
      rem = rem0;
    end
  end

  assign a_w = $signed({1'b0, rem[18:0]}) - $signed({1'b0, PI_A});
  assign b_w = 20'(a_r) + $signed({1'b0, HALF_PI_A});

  always_comb begin
    if (cmd4_r == CMD_COSINE) begin
      if (b_w > $signed({1'b0, PI_A})) begin
        x_w = b_w - $signed({1'b0, TWO_PI_A});
      end else begin
        x_w = b_w;
      end
    end else begin
      x_w = 20'(a_r);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[0]) begin
      u1_r   <= u_sum[32:0];
      cmd1_r <= in_cmd;
    end
    if (ctrl.en[1]) begin
      q_r    <= q_prod[38:25];
      u2_r   <= u1_r;
      cmd2_r <= cmd1_r;
    end
    if (ctrl.en[2]) begin
      qt_r   <= qt_prod;
      u3_r   <= u2_r;
      cmd3_r <= cmd2_r;
    end
    if (ctrl.en[3]) begin
      a_r    <= a_w[X_W-1:0];
      cmd4_r <= cmd3_r;
    end
    if (ctrl.en[4]) begin
      x_r <= x_w[X_W-1:0];
    end
  end

  assign x_out = x_r;

endmodule
`default_nettype wire

// ===== hdl/psc_parabola.sv =====
`default_nettype none
module psc_parabola import psc_pkg::*; (
  input  wire logic                  clk,
  input  wire psc_ctrl_t             ctrl,
  input  wire logic signed [X_W-1:0] x_in,
  output logic signed [VALUE_W-1:0]  value_out
);

  localparam int S = RED_STAGES;

  // stage 6: 4/pi*x and x*x
  logic signed [52:0] t1_prod;
  logic signed [52:0] t1_sum;
  logic signed [37:0] sq_prod;
  logic signed [37:0] sq_sum;
  logic signed [31:0] t1_r;
  logic [31:0]        sq_r;
  logic               neg6_r;
  // stage 7: 4/pi^2*x*x
  logic [63:0]        t2_prod;
  logic [63:0]        t2_sum;
  logic [31:0]        t2_r;
  logic signed [31:0] t1_7_r;
  logic               neg7_r;
  // stage 8: first parabola
  logic signed [32:0] y_w;
  logic signed [32:0] y_abs;
  logic signed [31:0] y8_r;
  logic [30:0]        ay_r;
  // stage 9: y*|y|
  logic signed [63:0] p_prod;
  logic signed [63:0] p_sum;
  logic signed [31:0] p_r;
  logic signed [31:0] y9_r;
  // stage 10: error term
  logic signed [32:0] d_w;
  logic signed [31:0] d_r;
  logic signed [31:0] y10_r;
  // stage 11: scaled error
  logic signed [63:0] e_prod;
  logic signed [63:0] e_sum;
  logic signed [31:0] e_r;
  logic signed [31:0] y11_r;
  // stage 12: output rounding and clamp
  logic signed [33:0] r_w;
  logic signed [21:0] rr_w;
  logic signed [VALUE_W-1:0] sat_w;
  logic signed [VALUE_W-1:0] value_r;

  // the angle is taken at Q16; the 12-bit lift to Q28 is folded into the shifts
  assign t1_prod = 53'($signed({1'b0, K_FOUR_OVER_PI})) * 53'(x_in);
  assign t1_sum  = t1_prod + 53'sd524288;
  assign sq_prod = 38'(x_in) * 38'(x_in);
  assign sq_sum  = sq_prod + 38'sd8;

  assign t2_prod = 64'(sq_r) * 64'(K_FOUR_OVER_PI_SQ);
  assign t2_sum  = t2_prod + 64'h0000_0000_8000_0000;

  assign y_w   = neg7_r ? (33'(t1_7_r) + $signed({1'b0, t2_r}))
                        : (33'(t1_7_r) - $signed({1'b0, t2_r}));
  assign y_abs = y_w[32] ? -y_w : y_w;

  assign p_prod = 64'(y8_r) * 64'($signed({1'b0, ay_r}));
  assign p_sum  = p_prod + 64'sd134217728;

  assign d_w = 33'(p_r) - 33'(y9_r);

  assign e_prod = 64'(d_r) * 64'($signed({1'b0, K_REFINE}));
  assign e_sum  = e_prod + 64'sd2147483648;

  assign r_w  = 34'(e_r) + 34'(y11_r) + 34'sd2048;
  assign rr_w = r_w[33:12];

  always_comb begin
    if (rr_w > VALUE_MAX) begin
      sat_w = VALUE_MAX[VALUE_W-1:0];
    end else if (rr_w < VALUE_MIN) begin
      sat_w = VALUE_MIN[VALUE_W-1:0];
    end else begin
      sat_w = rr_w[VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[S]) begin
      t1_r   <= t1_sum[51:20];
      sq_r   <= sq_sum[35:4];
      neg6_r <= x_in[X_W-1];
    end
    if (ctrl.en[S+1]) begin
      t2_r   <= t2_sum[63:32];
      t1_7_r <= t1_r;
      neg7_r <= neg6_r;
    end
    if (ctrl.en[S+2]) begin
      y8_r <= y_w[31:0];
      ay_r <= y_abs[30:0];
    end
    if (ctrl.en[S+3]) begin
      p_r  <= p_sum[59:28];
      y9_r <= y8_r;
    end
    if (ctrl.en[S+4]) begin
      d_r   <= d_w[31:0];
      y10_r <= y9_r;
    end
    if (ctrl.en[S+5]) begin
      e_r   <= e_sum[63:32];
      y11_r <= y10_r;
    end
    if (ctrl.en[S+6]) begin
      value_r <= sat_w;
    end
  end

  assign value_out = value_r;

endmodule
`default_nettype wire

// ===== hdl/parabolic_sine_cosine.sv =====
// Parabolic sine/cosine: each beat carries cmd (0 sine, 1 cosine) and a signed Q15.16
// angle in radians; the result beat carries the approximation as signed Q1.16,
// saturated. The angle is reduced to -pi..pi with a reciprocal multiply and a
// remainder correction, shifted by pi/2 for cosine, passed through the parabola
// 4/pi*x - sgn(x)*4/pi^2*x*x and refined by 0.225*(y*|y| - y) + y. The datapath is a
// 12-stage pipeline with one register after every multiplier, and while the output is not
// stalled one beat is accepted every cycle. Each stage holds its own valid bit: a stall
// at the output fills empty stages first, and in_ready falls only once the whole
// pipeline is occupied. Results leave in input order; the block keeps no state
// between items.
`default_nettype none
module parabolic_sine_cosine import psc_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  psc_in_if.sink   in_ch,
  psc_out_if.source out_ch
);

  psc_ctrl_t             ctrl;
  logic                  out_valid;
  logic signed [X_W-1:0] x_red;
  logic signed [VALUE_W-1:0] value;

  psc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .out_ready (out_ch.ready),
    .ctrl      (ctrl),
    .out_valid (out_valid)
  );

  psc_reduce u_reduce (
    .clk      (clk),
    .ctrl     (ctrl),
    .in_cmd   (in_ch.cmd),
    .in_angle (in_ch.angle),
    .x_out    (x_red)
  );

  psc_parabola u_parabola (
    .clk       (clk),
    .ctrl      (ctrl),
    .x_in      (x_red),
    .value_out (value)
  );

  assign in_ch.ready  = ctrl.en[0];
  assign out_ch.valid = out_valid;
  assign out_ch.value = value;

endmodule
`default_nettype wire
